[rtl/core/fsp_pkg.sv]
// Shared types and constants for the flow sensor frame parser.
// Used by fsp_parser and flow_sensor_frame_parser_top; depends on nothing.
`default_nettype none

package fsp_pkg;

  localparam int unsigned FRAME_LENGTH = 9;
  localparam int unsigned POS_W        = 4;

  typedef logic [POS_W-1:0] pos_t;

  // Frame positions.
  localparam pos_t POS_HEADER   = 4'd0;
  localparam pos_t POS_SKIP     = 4'd1;
  localparam pos_t POS_X_LO     = 4'd2;
  localparam pos_t POS_Y_HI     = 4'd5;
  localparam pos_t POS_CHECKSUM = 4'd6;
  localparam pos_t POS_LAST     = pos_t'(FRAME_LENGTH - 1);

  // Configuration register indexes, taken from paddr[2].
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_TAIL   = 1'b1;

  localparam logic [7:0] HEADER_RESET = 8'hfe;
  localparam logic [7:0] TAIL_RESET   = 8'haa;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
  } fsp_result_t;

endpackage

`default_nettype wire

[rtl/core/fsp_parser.sv]
// Frame position tracker, payload capture and checksum check for one byte.
// Depends on fsp_pkg for positions and the result struct.
`default_nettype none

module fsp_parser
  import fsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [7:0]  header_value,
  output fsp_result_t      result
);

  pos_t       byte_position_r, byte_position_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [7:0] payload_r [4];
  logic       payload_we;
  logic [1:0] payload_idx;

  always_comb begin
    byte_position_nxt = byte_position_r;
    running_sum_nxt   = running_sum_r;
    payload_we        = 1'b0;
    payload_idx       = 2'(byte_position_r - POS_X_LO);
    result.valid      = 1'b0;
    result.speed_x    = {payload_r[1], payload_r[0]};
    result.speed_y    = {payload_r[3], payload_r[2]};
    if (byte_position_r == POS_HEADER) begin
      if (rx_byte == header_value) begin
        running_sum_nxt   = 8'd0;
        byte_position_nxt = POS_SKIP;
      end
    end else if (byte_position_r == POS_SKIP) begin
      byte_position_nxt = POS_X_LO;
    end else if (byte_position_r >= POS_X_LO && byte_position_r <= POS_Y_HI) begin
      payload_we        = 1'b1;
      running_sum_nxt   = running_sum_r + rx_byte;
      byte_position_nxt = byte_position_r + pos_t'(1);
    end else if (byte_position_r == POS_CHECKSUM) begin
      // A zero checksum is rejected even when it matches.
      result.valid      = (rx_byte == running_sum_r) && (rx_byte != 8'd0);
      byte_position_nxt = byte_position_r + pos_t'(1);
    end else if (byte_position_r < POS_LAST) begin
      byte_position_nxt = byte_position_r + pos_t'(1);
    end else begin
      byte_position_nxt = POS_HEADER;
    end
    result.valid = result.valid && accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r <= POS_HEADER;
      running_sum_r   <= 8'd0;
    end else if (accept) begin
      byte_position_r <= byte_position_nxt;
      running_sum_r   <= running_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && payload_we) begin
      payload_r[payload_idx] <= rx_byte;
    end
  end

  position_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    byte_position_r <= POS_LAST)
    else $error("frame position beyond the last byte");

  result_only_on_checksum: assert property (@(posedge clk) disable iff (!rst_n)
    result.valid |=> byte_position_r == POS_CHECKSUM + pos_t'(1))
    else $error("result produced outside the checksum byte");

endmodule

`default_nettype wire

[rtl/core/flow_sensor_frame_parser_top.sv]
// Top level of the flow sensor frame parser: config registers, parser, output buffer.
// Depends on fsp_pkg and fsp_parser.
//
// Usage:
//   The in_ channel carries one received serial byte per word (in_rx_byte). A word
//   is taken at a clock edge where in_valid is high and in_stall is low. Bytes are
//   tracked through a nine-byte frame: header, spare, X low/high, Y low/high,
//   checksum, spare, tail. When the checksum byte matches the 8-bit sum of the four
//   payload bytes and is nonzero, one word with out_speed_x and out_speed_y goes out.
//   The result is registered in the output register, or in the skid register behind a
//   stalled word. Throughput is one byte per cycle while in_stall is low; the position
//   and running-sum update is a single short stage. A two-entry output buffer (output
//   register plus skid register) lets bytes keep flowing while a result waits on
//   out_stall; in_stall rises only once both are full, and it is driven from a register.
//   The APB port holds header_value (address 0) and tail_value (address 4); write
//   them only while the block is idle. tail_value is readable but has no effect.
//   Synchronous reset (rst_n low) returns to the header position, clears the sum,
//   empties the output buffer and restores header 0xFE and tail 0xAA.
`default_nettype none

module flow_sensor_frame_parser_top
  import fsp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_rx_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [15:0]         out_speed_x,
  output logic signed [15:0]         out_speed_y,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [7:0]  header_value_r;
  logic [7:0]  tail_value_r;
  logic        cfg_we;
  logic        in_accept;
  fsp_result_t result;

  logic               out_valid_r;
  logic signed [15:0] out_speed_x_r;
  logic signed [15:0] out_speed_y_r;
  logic               skid_valid_r;
  logic signed [15:0] skid_speed_x_r;
  logic signed [15:0] skid_speed_y_r;
  logic               out_pop;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_value_r <= HEADER_RESET;
      tail_value_r   <= TAIL_RESET;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_HEADER: header_value_r <= pwdata[7:0];
        REG_TAIL:   tail_value_r   <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HEADER: prdata = CFG_DATA_W'(header_value_r);
      REG_TAIL:   prdata = CFG_DATA_W'(tail_value_r);
      default:    prdata = '0;
    endcase
  end

  // Parser.
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !in_stall;

  fsp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .rx_byte      (in_rx_byte),
    .header_value (header_value_r),
    .result       (result)
  );

  // Output register with a skid register behind it.
  assign out_pop = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        // No byte is taken while the skid register is full.
        if (out_pop) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (result.valid) begin
        if (!out_valid_r || out_pop) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_speed_x_r <= skid_speed_x_r;
        out_speed_y_r <= skid_speed_y_r;
      end
    end else if (result.valid) begin
      if (!out_valid_r || out_pop) begin
        out_speed_x_r <= result.speed_x;
        out_speed_y_r <= result.speed_y;
      end else begin
        skid_speed_x_r <= result.speed_x;
        skid_speed_y_r <= result.speed_y;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_speed_x = out_speed_x_r;
  assign out_speed_y = out_speed_y_r;

  skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while the output register is empty");

  skid_fills_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid register filled without a stalled output");

  stalled_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled output word was dropped");

endmodule

`default_nettype wire
